// ===== rtl/timeline_frame_snapper_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIMELINE_FRAME_SNAPPER_MACROS_SVH
`define TIMELINE_FRAME_SNAPPER_MACROS_SVH

`ifndef SYNTH
`define TFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFS_ASSERT_IMP(lbl, ante, cons, msg)
`define TFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the frame snapper.
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam int DATA_W     = 64;
    localparam int TPF_W      = 61;
    localparam int CFG_W      = 31;
    localparam int TPS_W      = 30;
    localparam int DIV_STEPS  = 64;
    localparam int RATE_STEPS = 61;
    localparam int CNT_W      = 6;

    localparam logic [TPS_W-1:0] TICK_RATE_HZ = 30'd705600000;

    localparam logic [1:0] CFG_NUMERATOR   = 2'd0;
    localparam logic [1:0] CFG_DENOMINATOR = 2'd1;

    typedef enum logic [1:0] {
        OP_ROUND = 2'd0,
        OP_FLOOR = 2'd1,
        OP_LAST  = 2'd2,
        OP_SEEK  = 2'd3
    } op_t;

    // side data carried along the remainder pipeline
    typedef struct packed {
        op_t              op;
        logic             neg;
        logic             force_zero;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] d;
    } item_t;

    typedef struct packed {
        logic [TPF_W-1:0] tpf;
        logic             ok;
        logic             busy;
    } rate_t;

endpackage

// ===== rtl/tfs_rate.sv =====
// ----------------------------------------------------------------------------
// tfs_rate
// Rate registers and a bit-serial divider for ticks per frame.
// ----------------------------------------------------------------------------
module tfs_rate
    import tfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output rate_t            rate
);

    logic [CFG_W-1:0] numer_reg, numer_next;
    logic [CFG_W-1:0] denom_reg, denom_next;
    logic             load_reg, load_next;
    logic [TPF_W-1:0] n_reg, n_next;
    logic [TPF_W-1:0] q_reg, q_next;
    logic [CFG_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [TPF_W-1:0] prod;
    logic [CFG_W:0]   r_sh;
    logic [CFG_W:0]   r_sub;
    logic             ge;

    assign prod  = {{(TPF_W-TPS_W){1'b0}}, TICK_RATE_HZ} *
                   {{(TPF_W-CFG_W){1'b0}}, denom_reg};
    assign r_sh  = {r_reg, n_reg[TPF_W-1]};
    assign r_sub = r_sh - {1'b0, numer_reg};
    assign ge    = r_sh >= {1'b0, numer_reg};

    always_comb
    begin
        numer_next = numer_reg;
        denom_next = denom_reg;
        load_next  = load_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        if (load_reg)
        begin
            n_next    = prod;
            q_next    = '0;
            r_next    = '0;
            cnt_next  = CNT_W'(RATE_STEPS);
            load_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            n_next   = {n_reg[TPF_W-2:0], 1'b0};
            q_next   = {q_reg[TPF_W-2:0], ge};
            r_next   = ge ? r_sub[CFG_W-1:0] : r_sh[CFG_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
        if (cfg_we && cfg_index == CFG_NUMERATOR)
        begin
            numer_next = cfg_data;
            load_next  = 1'b1;
        end
        else if (cfg_we && cfg_index == CFG_DENOMINATOR)
        begin
            denom_next = cfg_data;
            load_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numer_reg <= CFG_W'(30);
            denom_reg <= CFG_W'(1);
            load_reg  <= 1'b1;
            n_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            numer_reg <= numer_next;
            denom_reg <= denom_next;
            load_reg  <= load_next;
            n_reg     <= n_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign rate.tpf  = q_reg;
    assign rate.ok   = (numer_reg != '0) && (denom_reg != '0) && (q_reg != '0);
    assign rate.busy = load_reg || (cnt_reg != '0);

endmodule

// ===== rtl/tfs_rem_pipe.sv =====
// ----------------------------------------------------------------------------
// tfs_rem_pipe
// Pipelined restoring remainder, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfs_rem_pipe
    import tfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [TPF_W-1:0]  tpf,
    input  logic              in_v,
    input  logic [DATA_W-1:0] in_q,
    input  item_t             in_info,
    output logic              out_v,
    output logic [TPF_W-1:0]  out_r,
    output item_t             out_info
);

    logic              v_reg    [DIV_STEPS];
    logic [TPF_W-1:0]  r_reg    [DIV_STEPS];
    logic [DATA_W-1:0] q_reg    [DIV_STEPS];
    item_t             info_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_stage
        logic              pv;
        logic [TPF_W-1:0]  pr;
        logic [DATA_W-1:0] pq;
        item_t             pinfo;
        logic [TPF_W:0]    sh;
        logic [TPF_W:0]    diff;

        if (i == 0)
        begin : g_first
            assign pv    = in_v;
            assign pr    = '0;
            assign pq    = in_q;
            assign pinfo = in_info;
        end
        else
        begin : g_next
            assign pv    = v_reg[i-1];
            assign pr    = r_reg[i-1];
            assign pq    = q_reg[i-1];
            assign pinfo = info_reg[i-1];
        end

        assign sh   = {pr, pq[DATA_W-1]};
        assign diff = sh - {1'b0, tpf};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]    <= (sh >= {1'b0, tpf}) ? diff[TPF_W-1:0] : sh[TPF_W-1:0];
                q_reg[i]    <= {pq[DATA_W-2:0], 1'b0};
                info_reg[i] <= pinfo;
            end
        end
    end

    assign out_v    = v_reg[DIV_STEPS-1];
    assign out_r    = r_reg[DIV_STEPS-1];
    assign out_info = info_reg[DIV_STEPS-1];

endmodule

// ===== rtl/tfs_snap.sv =====
// ----------------------------------------------------------------------------
// tfs_snap
// Euclidean remainder fixup, rounding, saturation, clamp and output register.
// ----------------------------------------------------------------------------
module tfs_snap
    import tfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              rate_ok,
    input  logic [TPF_W-1:0]  tpf,
    input  logic              in_v,
    input  logic [TPF_W-1:0]  in_r,
    input  item_t             in_info,
    output logic              out_v,
    output logic [DATA_W-1:0] out_ticks,
    output logic              out_valid
);

    localparam int SUM_W = DATA_W + 2;

    logic              f_v_reg;
    item_t             f_info_reg;
    logic [TPF_W-1:0]  f_rem_reg;
    logic              f_up_reg;
    logic              o_v_reg;
    logic [DATA_W-1:0] o_ticks_reg, o_ticks_next;
    logic              o_valid_reg, o_valid_next;

    logic [TPF_W-1:0]  rem_e;
    logic              up;
    logic [SUM_W-1:0]  base;
    logic [DATA_W-1:0] snapped;
    logic [DATA_W-1:0] xv;
    logic [DATA_W-1:0] hi;

    // remainder of a negative dividend folds to the Euclidean one
    always_comb
    begin
        if (in_info.neg && in_r != '0)
            rem_e = tpf - in_r;
        else
            rem_e = in_r;
        up = (in_info.op == OP_ROUND || in_info.op == OP_SEEK) &&
             ({rem_e, 1'b0} >= {1'b0, tpf});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_info_reg <= in_info;
            f_rem_reg  <= rem_e;
            f_up_reg   <= up;
        end
    end

    // frame multiple = x - rem (+ tpf when rounding up)
    always_comb
    begin
        base = {{2{f_info_reg.x[DATA_W-1]}}, f_info_reg.x}
               - {{(SUM_W-TPF_W){1'b0}}, f_rem_reg}
               + (f_up_reg ? {{(SUM_W-TPF_W){1'b0}}, tpf} : SUM_W'(0));
        if (base[SUM_W-1] && !(base[SUM_W-2] && base[SUM_W-3]))
            snapped = {1'b1, {(DATA_W-1){1'b0}}};
        else if (!base[SUM_W-1] && (base[SUM_W-2] || base[SUM_W-3]))
            snapped = {1'b0, {(DATA_W-1){1'b1}}};
        else
            snapped = base[DATA_W-1:0];

        xv = rate_ok ? snapped : f_info_reg.x;
        hi = f_info_reg.d[DATA_W-1] ? '0 : f_info_reg.d;

        o_valid_next = 1'b1;
        unique case (f_info_reg.op)
            OP_ROUND, OP_FLOOR:
            begin
                o_ticks_next = rate_ok ? snapped : '0;
                o_valid_next = rate_ok;
            end
            OP_LAST:
            begin
                o_ticks_next = f_info_reg.force_zero ? '0 : snapped;
            end
            OP_SEEK:
            begin
                if (xv[DATA_W-1])
                    o_ticks_next = '0;
                else if (xv > hi)
                    o_ticks_next = hi;
                else
                    o_ticks_next = xv;
            end
            default:
            begin
                o_ticks_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= in_v;
            o_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_ticks_reg <= o_ticks_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign out_v     = o_v_reg;
    assign out_ticks = o_ticks_reg;
    assign out_valid = o_valid_reg;

endmodule

// ===== rtl/timeline_frame_snapper.sv =====
// ----------------------------------------------------------------------------
// timeline_frame_snapper
// Snaps signed tick times to frame boundaries of a configurable frame rate.
// ----------------------------------------------------------------------------
// Items enter on the s_ group: s_tuser holds the operation, s_tdata the time
// and duration. Each item gives one result item on the m_ group: m_tdata is
// the snapped time, m_tuser[0] says whether a result exists.
// From acceptance to m_tvalid an item passes one entry register, 64 remainder
// stages (one quotient bit each), one fixup stage and the output register.
// Throughput is one item per cycle while the output is not stalled and no
// rate division runs. Writing either rate register starts a bit-serial
// division for ticks per frame; s_tready is low during it. After reset the
// same division runs once for the reset rate, and s_tready stays low until
// that division is done.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "timeline_frame_snapper_macros.svh"

module timeline_frame_snapper
    import tfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [127:0]     s_tdata,   // time_ticks, duration_ticks
    input  logic [1:0]       s_tuser,   // operation
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // result_ticks
    output logic [0:0]       m_tuser    // result_valid
);

    rate_t             rate;
    logic              en;
    logic              acc;
    logic              fv_reg;
    logic [DATA_W-1:0] fq_reg, fq_next;
    item_t             finfo_reg, finfo_next;
    logic [DATA_W-1:0] t_in;
    logic [DATA_W-1:0] d_in;
    logic              rp_v;
    logic [TPF_W-1:0]  rp_r;
    item_t             rp_info;
    logic              out_valid;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !rate.busy;
    assign acc      = s_tvalid && s_tready;
    assign t_in     = s_tdata[63:0];
    assign d_in     = s_tdata[127:64];

    tfs_rate u_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rate      (rate)
    );

    always_comb
    begin
        finfo_next.op = op_t'(s_tuser);
        finfo_next.d  = d_in;
        if (op_t'(s_tuser) == OP_LAST)
        begin
            finfo_next.x          = d_in - 1'b1;
            finfo_next.neg        = 1'b0;
            finfo_next.force_zero = d_in[DATA_W-1] || (d_in == '0) || !rate.ok;
            fq_next               = d_in - 1'b1;
        end
        else
        begin
            finfo_next.x          = t_in;
            finfo_next.neg        = t_in[DATA_W-1];
            finfo_next.force_zero = 1'b0;
            fq_next               = t_in[DATA_W-1] ? (~t_in + 1'b1) : t_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fq_reg    <= fq_next;
            finfo_reg <= finfo_next;
        end
    end

    tfs_rem_pipe u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tpf      (rate.tpf),
        .in_v     (fv_reg),
        .in_q     (fq_reg),
        .in_info  (finfo_reg),
        .out_v    (rp_v),
        .out_r    (rp_r),
        .out_info (rp_info)
    );

    tfs_snap u_snap (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .rate_ok   (rate.ok),
        .tpf       (rate.tpf),
        .in_v      (rp_v),
        .in_r      (rp_r),
        .in_info   (rp_info),
        .out_v     (m_tvalid),
        .out_ticks (m_tdata),
        .out_valid (out_valid)
    );

    assign m_tuser = out_valid;

    `TFS_ASSERT_IMP(a_no_accept_busy, rate.busy, !s_tready, "item accepted during rate division")
    `TFS_ASSERT_IMP(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "item accepted while stalled")
    `TFS_ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "invalid result not zero")
    `TFS_ASSERT_NXT(a_entry_valid, acc, fv_reg, "accepted item lost at entry")

endmodule

// ===== verif/tb_timeline_frame_snapper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timeline_frame_snapper
// Self-checking bench for the frame snapper: directed rows for the reset
// rate, extremes and the invalid rate, then random items over several rates,
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_timeline_frame_snapper
    import tfs_pkg::*;
();

    localparam longint unsigned SIGN = 64'h8000_0000_0000_0000;
    localparam longint unsigned TPS  = 64'd705600000;
    localparam int PIPE_WAIT = 80;

    typedef struct packed {
        logic [63:0] ticks;
        logic        ok;
    } snap_res_t;

    typedef struct {
        op_t         op;
        logic [63:0] t;
        logic [63:0] d;
        logic        known;
        snap_res_t   res;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = CFG_NUMERATOR;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [127:0]     s_tdata = '0;
    logic [1:0]       s_tuser = OP_ROUND;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [63:0]      m_tdata;
    logic [0:0]       m_tuser;

    timeline_frame_snapper dut (.*);

    always #5 clk = ~clk;

    // own copy of the rate registers
    longint unsigned rate_num = 30, rate_den = 1;
    snap_res_t       pending[$];
    int              n_err = 0;
    bit              hold_off = 1'b0;
    int              n_seen = 0;

    function automatic longint unsigned frame_ticks();
        if (rate_num == 0 || rate_den == 0)
            return 0;
        return (TPS * rate_den) / rate_num;
    endfunction

    function automatic longint unsigned frame_mult(bit neg, longint unsigned mag,
                                                   longint unsigned tpf);
        if (mag == 0)
            return 0;
        if (neg)
            return (mag > SIGN / tpf) ? SIGN : 64'd0 - mag * tpf;
        return (mag > (SIGN - 1) / tpf) ? SIGN - 1 : mag * tpf;
    endfunction

    function automatic longint unsigned snap_to_frame(longint unsigned t,
                                                      longint unsigned tpf, bit rnd);
        bit              neg;
        longint unsigned mag, rem, m;
        neg = t[63];
        if (!neg)
        begin
            mag = t / tpf;
            rem = t % tpf;
        end
        else
        begin
            m = 64'd0 - t;
            mag = m / tpf;
            rem = m % tpf;
            if (rem != 0)
            begin
                mag++;
                rem = tpf - rem;
            end
        end
        if (rnd && rem * 2 >= tpf)
            mag = neg ? mag - 1 : mag + 1;
        return frame_mult(neg, mag, tpf);
    endfunction

    function automatic snap_res_t predict_snap(op_t op, logic [63:0] t, logic [63:0] d);
        snap_res_t       r;
        longint unsigned tpf, x, hi;
        tpf = frame_ticks();
        r.ticks = '0;
        r.ok = 1'b1;
        case (op)
            OP_ROUND, OP_FLOOR:
                if (tpf == 0)
                    r.ok = 1'b0;
                else
                    r.ticks = snap_to_frame(t, tpf, op == OP_ROUND);
            OP_LAST:
                if (!d[63] && d != 0 && tpf != 0)
                    r.ticks = snap_to_frame(d - 1, tpf, 1'b0);
            default:
            begin
                x = (tpf != 0) ? snap_to_frame(t, tpf, 1'b1) : t;
                hi = d[63] ? 64'd0 : d;
                r.ticks = x[63] ? 64'd0 : (x > hi ? hi : x);
            end
        endcase
        return r;
    endfunction

    task automatic send_item(op_t op, logic [63:0] t, logic [63:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {d, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending.push_back(predict_snap(op, t, d));
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_rate(longint unsigned num, longint unsigned den);
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (PIPE_WAIT) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_NUMERATOR;
        cfg_data <= num[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_DENOMINATOR;
        cfg_data <= den[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        rate_num = num;
        rate_den = den;
    endtask

    function automatic logic [63:0] rand_ticks();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = {{34{v[63]}}, v[29:0]};
            1: v = {{44{v[63]}}, v[19:0]};
            2: v = 64'(($urandom_range(0, 40) - 20) * frame_ticks());
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_items(int count);
        repeat (count)
        begin
            send_item(op_t'($urandom_range(0, 3)), rand_ticks(), rand_ticks());
            maybe_gap();
        end
    endtask

    // receiver stall pattern, with a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (n_seen % 300 < 100)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        snap_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_seen <= n_seen + 1;
            if (pending.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected item ticks=%h ok=%b", $time, m_tdata, m_tuser);
            end
            else
            begin
                want = pending.pop_front();
                if (m_tdata !== want.ticks)
                begin
                    n_err++;
                    $display("%0t: result_ticks expected %h actual %h",
                             $time, want.ticks, m_tdata);
                end
                if (m_tuser[0] !== want.ok)
                begin
                    n_err++;
                    $display("%0t: result_valid expected %b actual %b",
                             $time, want.ok, m_tuser[0]);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeline_frame_snapper regression: fail");
        $finish;
    end

    initial
    begin
        // tpf at reset rate 30/1 is 23520000
        row_t rows[$];
        snap_res_t r;
        rows = '{
            '{OP_ROUND, 64'd0, 64'd0, 1, '{64'd0, 1'b1}},
            '{OP_ROUND, 64'd11760000, 64'd0, 1, '{64'd23520000, 1'b1}},
            '{OP_ROUND, 64'd11759999, 64'd0, 1, '{64'd0, 1'b1}},
            '{OP_ROUND, -64'sd11760000, 64'd0, 1, '{64'd0, 1'b1}},
            '{OP_ROUND, -64'sd11760001, 64'd0, 1, '{-64'sd23520000, 1'b1}},
            '{OP_FLOOR, -64'sd1, 64'd0, 1, '{-64'sd23520000, 1'b1}},
            '{OP_FLOOR, 64'd23519999, 64'd0, 1, '{64'd0, 1'b1}},
            '{OP_FLOOR, SIGN, 64'd0, 0, '{64'd0, 1'b0}},
            '{OP_FLOOR, SIGN - 1, 64'd0, 0, '{64'd0, 1'b0}},
            '{OP_ROUND, SIGN - 1, 64'd0, 0, '{64'd0, 1'b0}},
            '{OP_ROUND, SIGN, 64'd0, 0, '{64'd0, 1'b0}},
            '{OP_LAST, 64'hFFFF, 64'd0, 1, '{64'd0, 1'b1}},
            '{OP_LAST, 64'd0, SIGN, 1, '{64'd0, 1'b1}},
            '{OP_LAST, 64'd0, 64'd23520000, 1, '{64'd0, 1'b1}},
            '{OP_LAST, 64'd0, 64'd23520001, 1, '{64'd23520000, 1'b1}},
            '{OP_LAST, 64'd0, SIGN - 1, 0, '{64'd0, 1'b1}},
            '{OP_SEEK, -64'sd100, 64'd500, 1, '{64'd0, 1'b1}},
            '{OP_SEEK, 64'd99999999, 64'd5000, 1, '{64'd5000, 1'b1}},
            '{OP_SEEK, 64'd30000000, -64'sd7, 1, '{64'd0, 1'b1}},
            '{OP_SEEK, SIGN - 1, SIGN - 1, 0, '{64'd0, 1'b1}},
            '{OP_SEEK, SIGN, SIGN - 1, 0, '{64'd0, 1'b1}}
        };
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
        begin
            r = predict_snap(rows[i].op, rows[i].t, rows[i].d);
            if (rows[i].known && r !== rows[i].res)
            begin
                n_err++;
                $display("%0t: row %0d expected %h actual %h", $time, i, rows[i].res, r);
            end
            send_item(rows[i].op, rows[i].t, rows[i].d);
        end
        // long hold-off so the pipeline fills and stalls the input
        hold_off = 1'b1;
        fork
            random_items(150);
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
        join
        random_items(150);
        // invalid rates: numerator zero, denominator zero, tpf zero
        write_rate(0, 5);
        send_item(OP_ROUND, 64'd5, 64'd0);
        send_item(OP_SEEK, -64'sd5, 64'd9);
        send_item(OP_SEEK, 64'd50, 64'd9);
        random_items(60);
        write_rate(7, 0);
        random_items(60);
        write_rate(64'h7FFF_FFFF, 1);
        random_items(100);
        // largest tpf and extreme saturation
        write_rate(1, 64'h7FFF_FFFF);
        send_item(OP_ROUND, SIGN - 1, 64'd0);
        send_item(OP_FLOOR, SIGN, 64'd0);
        send_item(OP_LAST, 64'd0, SIGN - 1);
        random_items(150);
        write_rate(64'h7FFF_FFFF, 64'h7FFF_FFFF);
        random_items(150);
        write_rate(30000, 1001);
        random_items(200);
        write_rate($urandom_range(1, 120), $urandom_range(1, 1001));
        random_items(180);
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (PIPE_WAIT) @(negedge clk);
        if (n_err == 0)
            $display("timeline_frame_snapper regression: pass");
        else
            $display("timeline_frame_snapper regression: fail");
        $finish;
    end

endmodule
